// ----- rtl/core/multi_slot_alarm_scheduler_assert.svh -----
// ----------------------------------------------------------------------------
// multi_slot_alarm_scheduler_assert.svh
// assertion macros shared by the alarm scheduler rtl
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_ALARM_SCHEDULER_ASSERT_SVH
`define MULTI_SLOT_ALARM_SCHEDULER_ASSERT_SVH
`ifndef SYNTH
`define MSAS_ASSERT_IMP(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
    else $error("assertion failed");
`define MSAS_ASSERT_NXT(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define MSAS_ASSERT_IMP(lbl, ck, rn, a, c)
`define MSAS_ASSERT_NXT(lbl, ck, rn, a, c)
`endif
`endif

// ----- rtl/core/msas_pkg.sv -----
// ----------------------------------------------------------------------------
// msas_pkg
// shared types and constants of the alarm scheduler
// ----------------------------------------------------------------------------
package msas_pkg;

  localparam int TIME_W    = 64;
  localparam int MARGIN_W  = 32;
  localparam int IDX_W     = 6;
  localparam int DEF_SLOTS = 8;
  localparam int DEF_FIRES = 16;

  localparam logic [1:0] REQ_PASS   = 2'd0;
  localparam logic [1:0] REQ_SET    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_QUERY  = 2'd3;

  localparam logic [1:0] KIND_FIRED  = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  typedef struct packed {
    logic              set;
    logic              set_exp;
    logic              clr;
    logic              fire;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] expiry;
    logic [TIME_W-1:0] period;
    logic              periodic;
  } cmd_t;

  typedef struct packed {
    logic              pulse;
    logic              found;
    logic [TIME_W-1:0] exp;
    logic [IDX_W-1:0]  idx;
  } tok_t;

endpackage

// ----- rtl/core/msas_cell.sv -----
// ----------------------------------------------------------------------------
// msas_cell
// one alarm slot: stores the slot and passes the running minimum onward
// ----------------------------------------------------------------------------
module msas_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  msas_pkg::cmd_t cmd,
  input  msas_pkg::tok_t tok_in,
  output msas_pkg::tok_t tok_out,
  output logic          eq,
  output logic          armed
);
  import msas_pkg::*;

  logic [TIME_W-1:0] expiry_r, expiry_nxt;
  logic [TIME_W-1:0] period_r, period_nxt;
  logic              periodic_r, periodic_nxt;
  logic              armed_r, armed_nxt;
  tok_t              tok_r, tok_nxt;
  logic              sel;
  logic [TIME_W:0]   sum;

  assign sel   = (cmd.idx == IDX_W'(IDX));
  assign sum   = {1'b0, expiry_r} + {1'b0, period_r};
  assign eq    = (expiry_r == cmd.expiry);
  assign armed = armed_r;
  assign tok_out = tok_r;

  always_comb begin
    expiry_nxt   = expiry_r;
    period_nxt   = period_r;
    periodic_nxt = periodic_r;
    armed_nxt    = armed_r;
    if (sel && cmd.set) begin
      period_nxt   = cmd.period;
      periodic_nxt = cmd.periodic;
      if (cmd.set_exp) begin
        expiry_nxt = cmd.expiry;
        armed_nxt  = |cmd.expiry;
      end
    end
    if (sel && cmd.clr) begin
      expiry_nxt   = '0;
      period_nxt   = '0;
      periodic_nxt = 1'b0;
      armed_nxt    = 1'b0;
    end
    if (sel && cmd.fire) begin
      if (periodic_r) begin
        expiry_nxt = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
      end else begin
        armed_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.pulse && armed_r && (!tok_in.found || expiry_r < tok_in.exp)) begin
      tok_nxt.found = 1'b1;
      tok_nxt.exp   = expiry_r;
      tok_nxt.idx   = IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r   <= '0;
      period_r   <= '0;
      periodic_r <= 1'b0;
      armed_r    <= 1'b0;
      tok_r      <= '0;
    end else begin
      expiry_r   <= expiry_nxt;
      period_r   <= period_nxt;
      periodic_r <= periodic_nxt;
      armed_r    <= armed_nxt;
      tok_r      <= tok_nxt;
    end
  end

endmodule

// ----- rtl/core/multi_slot_alarm_scheduler.sv -----
// ----------------------------------------------------------------------------
// multi_slot_alarm_scheduler
// Alarm slots held in a row of cells. Every search for the earliest armed
// alarm walks the row one cell per clock; a request that fires alarms
// searches the row again after each alarm that it fires. A set with an
// unchanged expiry or an unknown slot gives no transaction.
// New requests are taken only when the previous one has finished.
// ----------------------------------------------------------------------------
`include "multi_slot_alarm_scheduler_assert.svh"
module multi_slot_alarm_scheduler #(
  parameter int NUM_SLOTS = msas_pkg::DEF_SLOTS,
  parameter int MAX_FIRES = msas_pkg::DEF_FIRES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_req_type,
  input  logic [msas_pkg::TIME_W-1:0]   in_now_ns,
  input  logic [2:0]                    in_slot,
  input  logic [msas_pkg::TIME_W-1:0]   in_expiry_ns,
  input  logic [msas_pkg::TIME_W-1:0]   in_period_ns,
  input  logic                          in_is_periodic,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_kind,
  output logic [2:0]                    out_fired_slot,
  output logic [msas_pkg::TIME_W-1:0]   out_next_delay_ns,
  output logic                          out_timer_armed,
  output logic                          out_slot_active,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [msas_pkg::MARGIN_W-1:0] cfg_data
);
  import msas_pkg::*;

  localparam int FW = $clog2(MAX_FIRES + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]          req_r, req_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [TIME_W-1:0]   ref_r, ref_nxt;
  logic [2:0]          slot_r, slot_nxt;
  logic [TIME_W-1:0]   exp_r, exp_nxt;
  logic [TIME_W-1:0]   per_r, per_nxt;
  logic                peri_r, peri_nxt;
  logic [FW-1:0]       fires_r, fires_nxt;
  logic                scan_start_r, scan_start_nxt;
  logic                res_found_r, res_found_nxt;
  logic [TIME_W-1:0]   res_exp_r, res_exp_nxt;
  logic [IDX_W-1:0]    res_idx_r, res_idx_nxt;
  logic [MARGIN_W-1:0] margin_r;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_kind_r, out_kind_nxt;
  logic [2:0]          out_slot_r, out_slot_nxt;
  logic [TIME_W-1:0]   out_delay_r, out_delay_nxt;
  logic                out_armed_r, out_armed_nxt;
  logic                out_active_r, out_active_nxt;
  logic                out_last_r, out_last_nxt;

  cmd_t                cmd;
  tok_t                chain [NUM_SLOTS+1];
  logic [NUM_SLOTS-1:0] eq_vec;
  logic [NUM_SLOTS-1:0] armed_vec;
  logic                eq_sel, armed_sel, slot_ok, out_free;
  logic [TIME_W:0]     ref_sum;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign slot_ok   = (32'(slot_r) < NUM_SLOTS);
  assign ref_sum   = {1'b0, in_now_ns} + {{(TIME_W+1-MARGIN_W){1'b0}}, margin_r};

  assign chain[0] = '{pulse: scan_start_r, found: 1'b0, exp: '0, idx: '0};

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    msas_cell #(.IDX(g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .tok_in (chain[g]),
      .tok_out(chain[g+1]),
      .eq     (eq_vec[g]),
      .armed  (armed_vec[g])
    );
  end

  always_comb begin
    eq_sel    = 1'b0;
    armed_sel = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (32'(slot_r) == i) begin
        eq_sel    = eq_vec[i];
        armed_sel = armed_vec[i];
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    now_nxt        = now_r;
    ref_nxt        = ref_r;
    slot_nxt       = slot_r;
    exp_nxt        = exp_r;
    per_nxt        = per_r;
    peri_nxt       = peri_r;
    fires_nxt      = fires_r;
    scan_start_nxt = 1'b0;
    res_found_nxt  = res_found_r;
    res_exp_nxt    = res_exp_r;
    res_idx_nxt    = res_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_slot_nxt   = out_slot_r;
    out_delay_nxt  = out_delay_r;
    out_armed_nxt  = out_armed_r;
    out_active_nxt = out_active_r;
    out_last_nxt   = out_last_r;
    cmd            = '0;
    cmd.idx        = IDX_W'(slot_r);
    cmd.expiry     = exp_r;
    cmd.period     = per_r;
    cmd.periodic   = peri_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_type;
          now_nxt   = in_now_ns;
          ref_nxt   = ref_sum[TIME_W] ? '1 : ref_sum[TIME_W-1:0];
          slot_nxt  = in_slot;
          exp_nxt   = in_expiry_ns;
          per_nxt   = in_period_ns;
          peri_nxt  = in_is_periodic;
          fires_nxt = '0;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (req_r)
          REQ_PASS: begin
            scan_start_nxt = 1'b1;
            state_nxt      = ST_SCAN;
          end
          REQ_SET: begin
            if (!slot_ok) begin
              state_nxt = ST_IDLE;
            end else begin
              cmd.set     = 1'b1;
              cmd.set_exp = !eq_sel;
              if (eq_sel) begin
                state_nxt = ST_IDLE;
              end else begin
                scan_start_nxt = 1'b1;
                state_nxt      = ST_SCAN;
              end
            end
          end
          REQ_REMOVE: begin
            cmd.clr        = slot_ok;
            scan_start_nxt = 1'b1;
            state_nxt      = ST_SCAN;
          end
          default: begin
            if (out_free) begin
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = KIND_STATUS;
              out_slot_nxt   = slot_r;
              out_delay_nxt  = '0;
              out_armed_nxt  = 1'b0;
              out_active_nxt = slot_ok && armed_sel;
              out_last_nxt   = 1'b1;
              state_nxt      = ST_IDLE;
            end
          end
        endcase
      end
      ST_SCAN: begin
        if (chain[NUM_SLOTS].pulse) begin
          res_found_nxt = chain[NUM_SLOTS].found;
          res_exp_nxt   = chain[NUM_SLOTS].exp;
          res_idx_nxt   = chain[NUM_SLOTS].idx;
          state_nxt     = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_active_nxt = 1'b0;
          if (res_found_r && res_exp_r <= ref_r && fires_r < FW'(MAX_FIRES)) begin
            cmd.fire       = 1'b1;
            cmd.idx        = res_idx_r;
            out_kind_nxt   = KIND_FIRED;
            out_slot_nxt   = res_idx_r[2:0];
            out_delay_nxt  = '0;
            out_armed_nxt  = 1'b0;
            out_last_nxt   = 1'b0;
            fires_nxt      = fires_r + FW'(1);
            scan_start_nxt = 1'b1;
            state_nxt      = ST_SCAN;
          end else begin
            out_kind_nxt  = KIND_DONE;
            out_slot_nxt  = '0;
            out_delay_nxt = (res_found_r && res_exp_r > now_r) ? res_exp_r - now_r : '0;
            out_armed_nxt = res_found_r;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scan_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
      margin_r     <= '0;
      fires_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      scan_start_r <= scan_start_nxt;
      out_valid_r  <= out_valid_nxt;
      fires_r      <= fires_nxt;
      if (cfg_valid && cfg_ready) begin
        margin_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    now_r        <= now_nxt;
    ref_r        <= ref_nxt;
    slot_r       <= slot_nxt;
    exp_r        <= exp_nxt;
    per_r        <= per_nxt;
    peri_r       <= peri_nxt;
    res_found_r  <= res_found_nxt;
    res_exp_r    <= res_exp_nxt;
    res_idx_r    <= res_idx_nxt;
    out_kind_r   <= out_kind_nxt;
    out_slot_r   <= out_slot_nxt;
    out_delay_r  <= out_delay_nxt;
    out_armed_r  <= out_armed_nxt;
    out_active_r <= out_active_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_fired_slot    = out_slot_r;
  assign out_next_delay_ns = out_delay_r;
  assign out_timer_armed   = out_armed_r;
  assign out_slot_active   = out_active_r;
  assign out_last          = out_last_r;

  `MSAS_ASSERT_IMP(a_fire_found, clk, rst_n, cmd.fire, res_found_r && state_r == ST_DECIDE)
  `MSAS_ASSERT_IMP(a_fires_cap, clk, rst_n, 1'b1, fires_r <= FW'(MAX_FIRES))
  `MSAS_ASSERT_IMP(a_scan_end, clk, rst_n, chain[NUM_SLOTS].pulse, state_r == ST_SCAN)
  `MSAS_ASSERT_NXT(a_fire_rescan, clk, rst_n, cmd.fire, scan_start_r && state_r == ST_SCAN)

endmodule
